// ----- sv/stq_pkg.sv -----
package stq_pkg;

    localparam int STQ_MAX_TIMERS  = 16;
    localparam int STQ_MAX_RESULTS = 16;
    localparam int STQ_RES_CNT_W   = $clog2(STQ_MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ADD    = 2'd1,
        OP_CANCEL = 2'd2,
        OP_CLEAR  = 2'd3
    } op_kind_t;

    typedef enum logic [2:0] {
        RES_EXPIRED     = 3'd0,
        RES_ADDED       = 3'd1,
        RES_FULL        = 3'd2,
        RES_CANCELLED   = 3'd3,
        RES_NOT_FOUND   = 3'd4,
        RES_ALL_CLEARED = 3'd5,
        RES_NOTHING_DUE = 3'd6
    } res_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_CMP,
        S_APPLY,
        S_REPORT
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LEFT,
        CELL_RIGHT,
        CELL_NEW
    } cell_op_t;

    typedef enum logic {
        CMP_EARLIER,
        CMP_ID
    } cmp_mode_t;

    typedef struct packed {
        logic [31:0] deadline;
        logic [15:0] id;
        logic [7:0]  code;
        logic [31:0] data;
    } entry_t;

    typedef struct packed {
        cell_op_t  op;
        logic      cmp_en;
        cmp_mode_t cmp_mode;
    } cell_ctrl_t;

    typedef struct packed {
        logic [31:0] now;
        logic [15:0] rel;
        logic [15:0] cid;
    } cmp_req_t;

    function automatic logic head_due(input logic [31:0] deadline, input logic [31:0] now);
        logic [31:0] diff;
        diff = deadline - now;
        return (diff == 32'd0) || diff[31];
    endfunction

    function automatic logic [15:0] head_dist(input logic [31:0] deadline,
                                              input logic [31:0] now);
        logic [31:0] diff;
        diff = deadline - now;
        if ((diff == 32'd0) || diff[31])
            return 16'd0;
        else if (|diff[31:16])
            return 16'hFFFF;
        else
            return diff[15:0];
    endfunction

endpackage

// ----- sv/stq_cell.sv -----
module stq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  stq_pkg::cell_ctrl_t ctrl,
    input  logic                valid,
    input  stq_pkg::cmp_req_t   req,
    input  stq_pkg::entry_t     left_entry,
    input  stq_pkg::entry_t     right_entry,
    input  stq_pkg::entry_t     new_entry,
    output stq_pkg::entry_t     entry,
    output logic                match
);
    import stq_pkg::*;

    entry_t      entry_reg;
    entry_t      entry_next;
    logic        match_reg;
    logic        match_next;
    logic [31:0] rel_left;

    always_comb
    begin
        case (ctrl.op)
            CELL_LEFT:  entry_next = left_entry;
            CELL_RIGHT: entry_next = right_entry;
            CELL_NEW:   entry_next = new_entry;
            default:    entry_next = entry_reg;
        endcase
    end

    // time left on this entry, overdue counts as zero
    always_comb
    begin
        rel_left = entry_reg.deadline - req.now;
        if (rel_left[31])
            rel_left = 32'd0;
        case (ctrl.cmp_mode)
            CMP_EARLIER: match_next = valid && ({16'd0, req.rel} < rel_left);
            CMP_ID:      match_next = valid && (req.cid != 16'd0) && (entry_reg.id == req.cid);
            default:     match_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_reg <= 1'b0;
        else if (ctrl.cmp_en)
            match_reg <= match_next;
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

// ----- sv/sorted_timer_queue.sv -----
// Sorted one-shot timer queue. Timers sit in a row of cells ordered by deadline,
// cell 0 holding the nearest; inserts and removals shift the row by one cell.
// An add or a cancel steps through transfer, per-cell compare, shift and report;
// a full add or a cancel-all goes from transfer straight to report, and a tick
// repeats a head check and a report per expired timer, at most STQ_MAX_RESULTS
// of them, or does one head check and report when none is due.
// Each result waits in the output register until it transfers; the sequencer holds
// while that register is occupied and stalled.
module sorted_timer_queue #(
    parameter int MAX_TIMERS = stq_pkg::STQ_MAX_TIMERS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [15:0] delay_ms,
    input  logic [15:0] cancel_id,
    input  logic [7:0]  handler_code,
    input  logic [31:0] handler_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  result_kind,
    output logic [15:0] result_id,
    output logic [7:0]  out_handler_code,
    output logic [31:0] out_handler_data,
    output logic [15:0] ms_to_next,
    output logic        queue_empty,
    output logic        last_result
);
    import stq_pkg::*;

    localparam int CntW = $clog2(MAX_TIMERS + 1);

    state_t                  state_reg;
    state_t                  state_next;
    op_kind_t                op_reg;
    logic [15:0]             delay_reg;
    logic [15:0]             cid_reg;
    logic [7:0]              code_reg;
    logic [31:0]             data_reg;
    logic [31:0]             now_reg;
    logic [CntW-1:0]         count_reg;
    logic [15:0]             last_id_reg;
    logic [STQ_RES_CNT_W-1:0] nres_reg;
    res_kind_t               res_kind_reg;
    logic [15:0]             res_id_reg;
    logic [7:0]              res_code_reg;
    logic [31:0]             res_data_reg;

    logic                    out_valid_reg;
    res_kind_t               out_kind_reg;
    logic [15:0]             out_id_reg;
    logic [7:0]              out_code_reg;
    logic [31:0]             out_data_reg;
    logic [15:0]             out_dist_reg;
    logic                    out_empty_reg;
    logic                    out_last_reg;

    entry_t                  cell_entry [MAX_TIMERS];
    cell_ctrl_t              cell_ctrl [MAX_TIMERS];
    logic [MAX_TIMERS-1:0]   match_vec;
    entry_t                  new_entry;
    cmp_req_t                req;

    logic                    in_xfer;
    logic                    slot_free;
    logic                    head_due_now;
    logic                    more_due;
    logic                    found;
    logic [15:0]             new_id;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    assign head_due_now = (count_reg != CntW'(0))
                          && head_due(cell_entry[0].deadline, now_reg);
    assign more_due = (op_reg == OP_TICK) && (res_kind_reg == RES_EXPIRED)
                      && (nres_reg < STQ_RES_CNT_W'(STQ_MAX_RESULTS)) && head_due_now;
    assign found = |match_vec;
    assign new_id = ((last_id_reg + 16'd1) == 16'd0) ? 16'd1 : last_id_reg + 16'd1;

    assign req.now = now_reg;
    assign req.rel = delay_reg;
    assign req.cid = cid_reg;

    assign new_entry.deadline = now_reg + {16'd0, delay_reg};
    assign new_entry.id       = new_id;
    assign new_entry.code     = code_reg;
    assign new_entry.data     = data_reg;

    for (genvar g = 0; g < MAX_TIMERS; g++)
    begin : g_cell
        stq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl[g]),
            .valid       (CntW'(g) < count_reg),
            .req         (req),
            .left_entry  ((g == 0) ? new_entry : cell_entry[(g == 0) ? 0 : g - 1]),
            .right_entry ((g == MAX_TIMERS - 1) ? cell_entry[g]
                          : cell_entry[(g == MAX_TIMERS - 1) ? g : g + 1]),
            .new_entry   (new_entry),
            .entry       (cell_entry[g]),
            .match       (match_vec[g])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    case (op_kind_t'(kind))
                        OP_TICK:   state_next = S_TICK;
                        OP_ADD:    state_next = (count_reg >= CntW'(MAX_TIMERS)) ? S_REPORT
                                                                                 : S_CMP;
                        OP_CANCEL: state_next = S_CMP;
                        default:   state_next = S_REPORT;
                    endcase
                end
            end
            S_TICK:   state_next = S_REPORT;
            S_CMP:    state_next = S_APPLY;
            S_APPLY:  state_next = S_REPORT;
            S_REPORT:
            begin
                if (slot_free)
                    state_next = more_due ? S_TICK : S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // shift control: a cell moves on a match at or before it, or on a due tick
    always_comb
    begin
        logic [MAX_TIMERS-1:0] low_mask;
        logic                  prior_match;
        logic                  at_count;
        logic                  upto_count;
        for (int i = 0; i < MAX_TIMERS; i++)
        begin
            low_mask    = (MAX_TIMERS'(1) << i) - MAX_TIMERS'(1);
            prior_match = |(match_vec & low_mask);
            at_count    = (CntW'(i) == count_reg);
            upto_count  = (CntW'(i) <= count_reg);
            cell_ctrl[i].op       = CELL_HOLD;
            cell_ctrl[i].cmp_en   = (state_reg == S_CMP);
            cell_ctrl[i].cmp_mode = (op_reg == OP_CANCEL) ? CMP_ID : CMP_EARLIER;
            case (state_reg)
                S_TICK:
                begin
                    if (head_due_now)
                        cell_ctrl[i].op = CELL_RIGHT;
                end
                S_APPLY:
                begin
                    if (op_reg == OP_ADD)
                    begin
                        if (prior_match && upto_count)
                            cell_ctrl[i].op = CELL_LEFT;
                        else if (!prior_match && (match_vec[i] || at_count))
                            cell_ctrl[i].op = CELL_NEW;
                    end
                    else if (prior_match || match_vec[i])
                        cell_ctrl[i].op = CELL_RIGHT;
                end
                default: cell_ctrl[i].op = CELL_HOLD;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            op_reg      <= OP_TICK;
            now_reg     <= 32'd0;
            count_reg   <= '0;
            last_id_reg <= 16'd1;
            nres_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        op_reg   <= op_kind_t'(kind);
                        nres_reg <= '0;
                        if (op_kind_t'(kind) == OP_TICK)
                            now_reg <= now_reg + 32'd1;
                        if (op_kind_t'(kind) == OP_CLEAR)
                        begin
                            count_reg   <= '0;
                            last_id_reg <= 16'd1;
                        end
                    end
                end
                S_TICK:
                begin
                    if (head_due_now)
                    begin
                        count_reg <= count_reg - CntW'(1);
                        nres_reg  <= nres_reg + STQ_RES_CNT_W'(1);
                    end
                end
                S_APPLY:
                begin
                    if (op_reg == OP_ADD)
                    begin
                        count_reg   <= count_reg + CntW'(1);
                        last_id_reg <= new_id;
                    end
                    else if (found)
                        count_reg <= count_reg - CntW'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    delay_reg    <= delay_ms;
                    cid_reg      <= cancel_id;
                    code_reg     <= handler_code;
                    data_reg     <= handler_data;
                    res_id_reg   <= 16'd0;
                    res_code_reg <= 8'd0;
                    res_data_reg <= 32'd0;
                    res_kind_reg <= (op_kind_t'(kind) == OP_ADD) ? RES_FULL : RES_ALL_CLEARED;
                end
            end
            S_TICK:
            begin
                if (head_due_now)
                begin
                    res_kind_reg <= RES_EXPIRED;
                    res_id_reg   <= cell_entry[0].id;
                    res_code_reg <= cell_entry[0].code;
                    res_data_reg <= cell_entry[0].data;
                end
                else
                begin
                    res_kind_reg <= RES_NOTHING_DUE;
                    res_id_reg   <= 16'd0;
                    res_code_reg <= 8'd0;
                    res_data_reg <= 32'd0;
                end
            end
            S_APPLY:
            begin
                if (op_reg == OP_ADD)
                begin
                    res_kind_reg <= RES_ADDED;
                    res_id_reg   <= new_id;
                end
                else if (found)
                begin
                    res_kind_reg <= RES_CANCELLED;
                    res_id_reg   <= cid_reg;
                end
                else
                begin
                    res_kind_reg <= RES_NOT_FOUND;
                    res_id_reg   <= 16'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if ((state_reg == S_REPORT) && slot_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_REPORT) && slot_free)
        begin
            out_kind_reg  <= res_kind_reg;
            out_id_reg    <= res_id_reg;
            out_code_reg  <= res_code_reg;
            out_data_reg  <= res_data_reg;
            out_dist_reg  <= (count_reg == CntW'(0)) ? 16'd0
                             : head_dist(cell_entry[0].deadline, now_reg);
            out_empty_reg <= (count_reg == CntW'(0));
            out_last_reg  <= !more_due;
        end
    end

    assign out_valid        = out_valid_reg;
    assign result_kind      = out_kind_reg;
    assign result_id        = out_id_reg;
    assign out_handler_code = out_code_reg;
    assign out_handler_data = out_data_reg;
    assign ms_to_next       = out_dist_reg;
    assign queue_empty      = out_empty_reg;
    assign last_result      = out_last_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(MAX_TIMERS))
        else $error("pending count beyond capacity");

    a_nres_range: assert property (@(posedge clk) disable iff (!rst_n)
        nres_reg <= STQ_RES_CNT_W'(STQ_MAX_RESULTS))
        else $error("too many expirations in one tick");

    a_not_last_expired: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_result |-> result_kind == RES_EXPIRED)
        else $error("non-final result that is not an expiration");

    a_empty_dist: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && queue_empty |-> ms_to_next == 16'd0)
        else $error("empty queue reports a distance");

    a_expire_pops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TICK) && head_due_now |=> count_reg == $past(count_reg) - CntW'(1))
        else $error("expiration did not remove the head");
`endif

endmodule
